// File: sv/mts_pkg.sv
// Shared constants, types and table helpers for the multi-tone sine synthesizer.
`default_nettype none

package mts_pkg;

	localparam int NUM_TONES_DEF  = 8;
	localparam int SINE_DEPTH_DEF = 1024;

	localparam int PHASE_W  = 32;
	localparam int GAIN_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int ACT_W    = 4;
	localparam int IDX_W    = 3;
	localparam int MAG_W    = 15;

	localparam logic [ACT_W-1:0] ACTIVE_RESET = 4'd8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

	localparam int ROUND_HALF = 16384;
	localparam int FRAC_SHIFT = 15;

	typedef struct packed {
		logic                      en;
		logic [PHASE_W-1:0]        step;
		logic [PHASE_W-1:0]        phase;
		logic signed [GAIN_W-1:0]  gain;
	} tone_wr_t;

	typedef struct packed {
		logic                      valid;
		logic [PHASE_W-1:0]        step;
		logic [PHASE_W-1:0]        phase;
		logic signed [GAIN_W-1:0]  gain;
	} tone_rd_t;

	typedef struct packed {
		logic clear;
		logic acc_en;
	} mac_ctrl_t;

	// Two Q30 multiplications by the angle, as one Taylor term feeds the next.
	function automatic logic [63:0] taylor_sq(input logic [63:0] m, input logic [63:0] x);
		logic [63:0] t;
		t = (m * x) >> 30;
		return (t * x) >> 30;
	endfunction

endpackage

`default_nettype wire

// File: sv/mts_tone_store.sv
// Tone tables: phase step, phase accumulator and gain memories with per-tone valid bits.
`default_nettype none

module mts_tone_store #(
	parameter int NUM_TONES = mts_pkg::NUM_TONES_DEF,
	localparam int TW = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mts_pkg::tone_wr_t wr,
	input  wire logic [TW-1:0]     wr_index,
	input  wire logic              rd_en,
	input  wire logic [TW-1:0]     rd_index,
	input  wire logic              upd_en,
	input  wire logic [TW-1:0]     upd_index,
	input  wire logic [mts_pkg::PHASE_W-1:0] upd_phase,
	output mts_pkg::tone_rd_t      rd
);

	logic [mts_pkg::PHASE_W-1:0]       step_mem [NUM_TONES];
	logic [mts_pkg::PHASE_W-1:0]       acc_mem  [NUM_TONES];
	logic signed [mts_pkg::GAIN_W-1:0] gain_mem [NUM_TONES];

	logic [NUM_TONES-1:0]              valid_q;
	logic                              valid_rd_q;
	logic [mts_pkg::PHASE_W-1:0]       step_rd_q;
	logic [mts_pkg::PHASE_W-1:0]       acc_rd_q;
	logic signed [mts_pkg::GAIN_W-1:0] gain_rd_q;

	logic [TW-1:0]                     acc_wa;
	logic [mts_pkg::PHASE_W-1:0]       acc_wd;

	assign acc_wa = wr.en ? wr_index : upd_index;
	assign acc_wd = wr.en ? wr.phase : upd_phase;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			step_mem[wr_index] <= wr.step;
			gain_mem[wr_index] <= wr.gain;
		end
		if (wr.en || upd_en) begin
			acc_mem[acc_wa] <= acc_wd;
		end
		if (rd_en) begin
			step_rd_q <= step_mem[rd_index];
			acc_rd_q  <= acc_mem[rd_index];
			gain_rd_q <= gain_mem[rd_index];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr_index] <= 1'b1;
			end
			if (rd_en) begin
				valid_rd_q <= valid_q[rd_index];
			end
		end
	end

	// A tone that was never loaded reads as silent and still.
	assign rd.valid = valid_rd_q;
	assign rd.step  = valid_rd_q ? step_rd_q : '0;
	assign rd.phase = valid_rd_q ? acc_rd_q : '0;
	assign rd.gain  = valid_rd_q ? gain_rd_q : '0;

endmodule

`default_nettype wire

// File: sv/mts_sine_rom.sv
// Quarter-wave sine ROM with quadrant folding and a registered read.
`default_nettype none

module mts_sine_rom #(
	parameter int SINE_TABLE_DEPTH = mts_pkg::SINE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic [mts_pkg::PHASE_W-1:0] phase,
	output logic [mts_pkg::MAG_W-1:0]        mag_s2,
	output logic                             neg_s2
);

	localparam int QUARTER = SINE_TABLE_DEPTH / 4;
	localparam int QBITS   = $clog2(QUARTER);
	localparam int AW      = QBITS + 1;

	logic [mts_pkg::MAG_W-1:0] rom [0:QUARTER];

	for (genvar j = 0; j <= QUARTER; j++) begin : g_rom
		localparam logic [63:0] X   = (mts_pkg::HALF_PI_Q30 * 64'(j)) / QUARTER;
		localparam logic [63:0] M3  = mts_pkg::taylor_sq(X, X) / 6;
		localparam logic [63:0] M5  = mts_pkg::taylor_sq(M3, X) / 20;
		localparam logic [63:0] M7  = mts_pkg::taylor_sq(M5, X) / 42;
		localparam logic [63:0] M9  = mts_pkg::taylor_sq(M7, X) / 72;
		localparam logic [63:0] M11 = mts_pkg::taylor_sq(M9, X) / 110;
		localparam logic [63:0] M13 = mts_pkg::taylor_sq(M11, X) / 156;
		localparam logic [63:0] M15 = mts_pkg::taylor_sq(M13, X) / 210;
		localparam logic [63:0] M17 = mts_pkg::taylor_sq(M15, X) / 272;
		localparam logic signed [63:0] S = $signed(X) - $signed(M3) + $signed(M5)
			- $signed(M7) + $signed(M9) - $signed(M11) + $signed(M13)
			- $signed(M15) + $signed(M17);
		localparam logic [63:0] SP = (S < 0) ? 64'd0 : $unsigned(S);
		localparam logic [63:0] V  = (SP * 64'd32767 + (mts_pkg::ONE_Q30 >> 1)) >> 30;
		localparam logic [mts_pkg::MAG_W-1:0] ENTRY = (V > 64'd32767) ? 15'h7fff : V[14:0];
		assign rom[j] = ENTRY;
	end

	logic [QBITS-1:0] k;
	logic [AW-1:0]    addr;

	assign k    = phase[29 -: QBITS];
	assign addr = phase[30] ? (AW'(QUARTER) - {1'b0, k}) : {1'b0, k};

	always_ff @(posedge clk) begin
		mag_s2 <= rom[addr];
		neg_s2 <= phase[31];
	end

endmodule

`default_nettype wire

// File: sv/mts_mac.sv
// Shared multiply-accumulate with final rounding and saturation.
`default_nettype none

module mts_mac #(
	parameter int NUM_TONES = mts_pkg::NUM_TONES_DEF
) (
	input  wire logic                              clk,
	input  wire mts_pkg::mac_ctrl_t                ctrl,
	input  wire logic signed [mts_pkg::GAIN_W-1:0] gain_s2,
	input  wire logic [mts_pkg::MAG_W-1:0]         mag_s2,
	input  wire logic                              neg_s2,
	output logic signed [mts_pkg::SAMPLE_W-1:0]    sample_o,
	output logic                                   clip_o
);

	localparam int SUM_W = 32 + $clog2(NUM_TONES) + 1;
	localparam int SH_W  = SUM_W - mts_pkg::FRAC_SHIFT;
	localparam int PR_W  = mts_pkg::GAIN_W + mts_pkg::MAG_W + 2;

	logic signed [mts_pkg::MAG_W+1:0] sine_v;
	logic signed [PR_W-1:0]           product_s3;
	logic signed [SUM_W-1:0]          sum_q;
	logic signed [SUM_W-1:0]          rnd;
	logic signed [SH_W-1:0]           shifted;

	assign sine_v = neg_s2 ? -$signed({2'b00, mag_s2}) : $signed({2'b00, mag_s2});

	always_ff @(posedge clk) begin
		product_s3 <= gain_s2 * sine_v;
		if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.acc_en) begin
			sum_q <= sum_q + SUM_W'(product_s3);
		end
	end

	assign rnd     = sum_q + SUM_W'(mts_pkg::ROUND_HALF);
	assign shifted = $signed(rnd[SUM_W-1:mts_pkg::FRAC_SHIFT]);

	always_comb begin
		if (shifted > 32767) begin
			sample_o = 16'sh7fff;
			clip_o   = 1'b1;
		end else if (shifted < -32768) begin
			sample_o = 16'sh8000;
			clip_o   = 1'b1;
		end else begin
			sample_o = shifted[mts_pkg::SAMPLE_W-1:0];
			clip_o   = 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: sv/multi_tone_sine_synthesizer.sv
// Top level: tone sequencer driving the shared tone store, sine ROM and multiply-accumulate.
//
//  channel   direction  handshake          payload
//  input     in         in_valid/in_stall  op, tone_index, phase_step, start_phase, gain
//  output    out        out_valid/out_stall sample, clipped
//  config    in         cfg_we             cfg_data (active tone count)
//
// A tick stalls the input from its transfer to the next acceptance, as the tones pass one a
// cycle through the single ROM port and multiplier.
// Reset clears the tone valid bits at once, so no clearing pass is needed.
// A stalled result waits in the output register; a new item is taken meanwhile, and a
// further tick holds in its final step until the waiting result has been transferred.
`default_nettype none

module multi_tone_sine_synthesizer #(
	parameter int NUM_TONES        = mts_pkg::NUM_TONES_DEF,
	parameter int SINE_TABLE_DEPTH = mts_pkg::SINE_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               op,
	input  wire logic [mts_pkg::IDX_W-1:0]          tone_index,
	input  wire logic [mts_pkg::PHASE_W-1:0]        phase_step,
	input  wire logic [mts_pkg::PHASE_W-1:0]        start_phase,
	input  wire logic signed [mts_pkg::GAIN_W-1:0]  gain,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [mts_pkg::SAMPLE_W-1:0]     sample,
	output logic                                    clipped,
	input  wire logic                               cfg_we,
	input  wire logic [mts_pkg::ACT_W-1:0]          cfg_data
);

	localparam int TW = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t                            state_q;
	logic [mts_pkg::ACT_W-1:0]         active_q;
	logic [TW-1:0]                     t_q;
	logic                              v_s1, v_s2, v_s3;
	logic                              act_s1, act_s2, act_s3;
	logic [TW-1:0]                     t_s1;
	logic signed [mts_pkg::GAIN_W-1:0] gain_s2;
	logic                              out_valid_q;
	logic signed [mts_pkg::SAMPLE_W-1:0] sample_q;
	logic                              clipped_q;

	logic                              in_xfer;
	logic                              tick_start;
	logic                              issue;
	logic                              fin_go;
	mts_pkg::tone_wr_t                 wr;
	mts_pkg::tone_rd_t                 rd;
	mts_pkg::mac_ctrl_t                mac_ctrl;
	logic [mts_pkg::MAG_W-1:0]         mag_s2;
	logic                              neg_s2;
	logic signed [mts_pkg::SAMPLE_W-1:0] mac_sample;
	logic                              mac_clip;

	assign in_stall   = (state_q != S_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign tick_start = in_xfer && (op == mts_pkg::OP_TICK);
	assign issue      = (state_q == S_RUN);
	assign fin_go     = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	assign wr.en    = in_xfer && (op == mts_pkg::OP_LOAD) && (32'(tone_index) < NUM_TONES);
	assign wr.step  = phase_step;
	assign wr.phase = start_phase;
	assign wr.gain  = gain;

	assign mac_ctrl.clear  = tick_start;
	assign mac_ctrl.acc_en = v_s3 && act_s3;

	mts_tone_store #(
		.NUM_TONES(NUM_TONES)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.wr_index  (TW'(tone_index)),
		.rd_en     (issue),
		.rd_index  (t_q),
		.upd_en    (v_s1 && rd.valid),
		.upd_index (t_s1),
		.upd_phase (rd.phase + rd.step),
		.rd        (rd)
	);

	mts_sine_rom #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_rom (
		.clk    (clk),
		.phase  (rd.phase),
		.mag_s2 (mag_s2),
		.neg_s2 (neg_s2)
	);

	mts_mac #(
		.NUM_TONES(NUM_TONES)
	) u_mac (
		.clk      (clk),
		.ctrl     (mac_ctrl),
		.gain_s2  (gain_s2),
		.mag_s2   (mag_s2),
		.neg_s2   (neg_s2),
		.sample_o (mac_sample),
		.clip_o   (mac_clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= mts_pkg::ACTIVE_RESET;
			t_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			act_s1      <= 1'b0;
			act_s2      <= 1'b0;
			act_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_data;
			end
			v_s1   <= issue;
			act_s1 <= issue && (32'(t_q) < 32'(active_q));
			v_s2   <= v_s1;
			act_s2 <= act_s1;
			v_s3   <= v_s2;
			act_s3 <= act_s2;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (tick_start) begin
						t_q     <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (t_q == TW'(NUM_TONES - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		t_s1    <= t_q;
		gain_s2 <= rd.gain;
		if (fin_go) begin
			sample_q  <= mac_sample;
			clipped_q <= mac_clip;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign clipped   = clipped_q;

endmodule

`default_nettype wire

// File: sv/mts_checker.sv
// Port-level checker for the multi-tone sine synthesizer, bound to the top level.
`default_nettype none

module mts_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic                              op,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic signed [mts_pkg::SAMPLE_W-1:0] sample,
	input wire logic                              clipped
);

	// A result that is held back keeps its value until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample) && $stable(clipped))
		else $error("stalled result changed");

	// A saturated sample sits at one end of the range.
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (sample == 16'sh7fff) || (sample == 16'sh8000))
		else $error("clipped flag without a rail value");

	// A tick keeps the input side busy in the following cycle.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == mts_pkg::OP_TICK) |=> in_stall)
		else $error("input taken right after a tick");

	// A load never produces a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == mts_pkg::OP_LOAD) && !out_valid |=> !out_valid)
		else $error("result appeared after a load");

endmodule

bind multi_tone_sine_synthesizer mts_checker u_mts_checker (.*);

`default_nettype wire
